>>> sv/assert_macros.svh
// assertion macros used by cstb_datapath of the screendump loader
// each check is clocked on aclk and held off while aresetn is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CSTB_ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication
`define CSTB_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> sv/cstb_pkg.sv
// types, constants and codes of the screendump loader
// used by cstb_ctrl, cstb_datapath and the top level; depends on nothing
package cstb_pkg;

    localparam int HEADER_BYTES  = 40;
    localparam int PAYLOAD_DEPTH = 8192;
    localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);
    // header and payload positions never pass 255*32+1
    localparam int CNT_W         = 14;

    localparam logic [7:0] SIG_COLON = 8'h3A;
    localparam logic [7:0] SIG_D     = 8'h44;

    // configuration register indexes
    localparam logic CFG_SKIP_CHECKS = 1'b0;
    localparam logic CFG_MAGNIFY     = 1'b1;

    // input opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_LOADING = 3'd0,
        ST_OK      = 3'd1,
        ST_SIG     = 3'd2,
        ST_HSUM    = 3'd3,
        ST_MARK    = 3'd4,
        ST_PSUM    = 3'd5,
        ST_SIZE    = 3'd6,
        ST_NOTHING = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_READY,
        PH_ERROR
    } phase_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_EXEC,
        CS_MEMRD,
        CS_FORM,
        CS_PUSH
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic mem_rd;
        logic form;
        logic push;
    } cstb_cmd_t;

    typedef struct packed {
        logic need_mem;
        logic slot_free;
    } cstb_stat_t;

endpackage

>>> sv/cstb_ctrl.sv
// sequencer of the screendump loader: take a word, execute, read memory and form the byte when needed, push result
// depends on cstb_pkg
module cstb_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  cstb_pkg::cstb_stat_t   stat,
    output cstb_pkg::cstb_cmd_t    cmd
);

    cstb_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cstb_pkg::CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cstb_pkg::CS_IDLE: begin
                if (s_valid) state_next = cstb_pkg::CS_EXEC;
            end
            cstb_pkg::CS_EXEC: begin
                state_next = stat.need_mem ? cstb_pkg::CS_MEMRD : cstb_pkg::CS_PUSH;
            end
            cstb_pkg::CS_MEMRD: begin
                state_next = cstb_pkg::CS_FORM;
            end
            cstb_pkg::CS_FORM: begin
                state_next = cstb_pkg::CS_PUSH;
            end
            cstb_pkg::CS_PUSH: begin
                if (stat.slot_free) state_next = cstb_pkg::CS_IDLE;
            end
            default: begin
                state_next = cstb_pkg::CS_IDLE;
            end
        endcase
    end

    // no word is taken while reset is held
    always_comb begin
        s_ready    = (state_reg == cstb_pkg::CS_IDLE) && aresetn;
        cmd.accept = (state_reg == cstb_pkg::CS_IDLE) && aresetn && s_valid;
        cmd.exec   = (state_reg == cstb_pkg::CS_EXEC);
        cmd.mem_rd = (state_reg == cstb_pkg::CS_MEMRD);
        cmd.form   = (state_reg == cstb_pkg::CS_FORM);
        cmd.push   = (state_reg == cstb_pkg::CS_PUSH) && stat.slot_free;
    end

endmodule

>>> sv/cstb_datapath.sv
// datapath of the screendump loader: parse state, payload memory, readout counters,
// result staging and output register; depends on cstb_pkg and assert_macros.svh
`include "assert_macros.svh"

module cstb_datapath (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_index,
    input  logic                     cfg_data,
    input  logic                     s_opcode,
    input  logic [7:0]               s_in_byte,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [7:0]               m_out_byte,
    output logic                     m_last_byte,
    output logic [2:0]               m_status,
    output logic [9:0]               m_picture_width,
    output logic [9:0]               m_picture_height,
    input  cstb_pkg::cstb_cmd_t      cmd,
    output cstb_pkg::cstb_stat_t     stat
);

    localparam int AW = cstb_pkg::ADDR_W;
    localparam int CW = cstb_pkg::CNT_W;

    // configuration
    logic skip_reg, magnify_reg;

    // accepted word
    logic       op_reg;
    logic [7:0] byte_reg;

    // parse and readout state
    cstb_pkg::phase_t  phase_reg, phase_next;
    cstb_pkg::status_t err_reg, err_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [7:0]        sum_reg, sum_next;
    logic [7:0]        rows_reg, rows_next;
    logic [7:0]        cols_reg, cols_next;
    logic [9:0]        orow_reg, orow_next;
    logic [7:0]        ocol_reg, ocol_next;

    // read pipeline
    logic [AW-1:0]     addr_reg;
    logic [1:0]        part_reg;
    logic              mag_used_reg;
    logic [7:0]        rd_data_reg;

    // result staging
    cstb_pkg::status_t res_status_reg, res_status_next;
    logic [7:0]        res_byte_reg;
    logic              res_last_reg, res_last_next;
    logic [9:0]        res_w_reg, res_w_next, res_h_reg, res_h_next;

    // output register
    logic              m_valid_reg;
    cstb_pkg::status_t m_status_reg;
    logic [7:0]        m_byte_reg;
    logic              m_last_reg;
    logic [9:0]        m_w_reg, m_h_reg;

    // payload memory
    logic [7:0]        mem [cstb_pkg::PAYLOAD_DEPTH];
    logic              wr_en;
    logic [AW-1:0]     wr_addr;

    // geometry
    logic [7:0]  bpr;
    logic [15:0] len_full;
    logic [7:0]  sum_plus;
    logic [9:0]  rows_eff;
    logic [7:0]  rb;
    logic [9:0]  r_a, r_n;
    logic [7:0]  c_a, c_inc, c_n;
    logic [7:0]  r_s, c_s;
    logic [15:0] prod;
    logic [16:0] addr_full;
    logic        rd_hit;
    logic        sig_bad;
    logic        last_hit;

    assign bpr      = 8'((9'(cols_reg) + 9'd7) >> 3);
    assign len_full = 16'(rows_reg) * 16'(bpr);
    assign sum_plus = sum_reg + byte_reg;

    // readout position, with a pending wrap to the next row applied first
    always_comb begin
        rows_eff = magnify_reg ? {rows_reg, 2'b00} : 10'(rows_reg);
        rb       = magnify_reg ? 8'((9'(cols_reg) + 9'd1) >> 1) : bpr;
        if (ocol_reg >= rb) begin
            c_a = 8'd0;
            r_a = orow_reg + 10'd1;
        end else begin
            c_a = ocol_reg;
            r_a = orow_reg;
        end
        c_inc = c_a + 8'd1;
        if (c_inc >= rb) begin
            c_n = 8'd0;
            r_n = r_a + 10'd1;
        end else begin
            c_n = c_inc;
            r_n = r_a;
        end
        r_s       = magnify_reg ? 8'(r_a >> 2) : 8'(r_a);
        c_s       = magnify_reg ? (c_a >> 2) : c_a;
        // column-major store, rightmost byte column first
        prod      = 16'(bpr - 8'd1 - c_s) * 16'(rows_reg);
        addr_full = 17'(prod) + 17'(r_s);
        last_hit  = (r_a == rows_eff - 10'd1) && (c_a == rb - 8'd1);
    end

    assign sig_bad = ((cnt_reg == CW'(0)) && (byte_reg != cstb_pkg::SIG_COLON))
                  || (((cnt_reg == CW'(1)) || (cnt_reg == CW'(2)))
                      && (byte_reg != cstb_pkg::SIG_D));

    always_comb begin
        phase_next      = phase_reg;
        err_next        = err_reg;
        cnt_next        = cnt_reg;
        sum_next        = sum_reg;
        rows_next       = rows_reg;
        cols_next       = cols_reg;
        orow_next       = orow_reg;
        ocol_next       = ocol_reg;
        res_status_next = cstb_pkg::ST_LOADING;
        res_last_next   = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = AW'(cnt_reg - CW'(1));
        rd_hit          = 1'b0;
        if (op_reg == cstb_pkg::OP_LOAD) begin
            unique case (phase_reg)
                cstb_pkg::PH_HEADER: begin
                    if (sig_bad) begin
                        phase_next      = cstb_pkg::PH_ERROR;
                        err_next        = cstb_pkg::ST_SIG;
                        res_status_next = cstb_pkg::ST_SIG;
                    end else begin
                        if (cnt_reg == CW'(3)) rows_next = byte_reg;
                        if (cnt_reg == CW'(4)) cols_next = byte_reg;
                        if (cnt_reg != CW'(cstb_pkg::HEADER_BYTES - 1)) begin
                            if (cnt_reg != CW'(0)) sum_next = sum_plus;
                            cnt_next = cnt_reg + CW'(1);
                        end else if (!skip_reg && (sum_plus != 8'd0)) begin
                            phase_next      = cstb_pkg::PH_ERROR;
                            err_next        = cstb_pkg::ST_HSUM;
                            res_status_next = cstb_pkg::ST_HSUM;
                        end else if ((rows_reg == 8'd0) || (cols_reg == 8'd0)
                                     || (32'(len_full) > 32'(cstb_pkg::PAYLOAD_DEPTH))) begin
                            phase_next      = cstb_pkg::PH_ERROR;
                            err_next        = cstb_pkg::ST_SIZE;
                            res_status_next = cstb_pkg::ST_SIZE;
                        end else begin
                            phase_next = cstb_pkg::PH_PAYLOAD;
                            cnt_next   = CW'(0);
                            sum_next   = 8'd0;
                        end
                    end
                end
                cstb_pkg::PH_PAYLOAD: begin
                    if (cnt_reg == CW'(0)) begin
                        if (byte_reg != cstb_pkg::SIG_COLON) begin
                            phase_next      = cstb_pkg::PH_ERROR;
                            err_next        = cstb_pkg::ST_MARK;
                            res_status_next = cstb_pkg::ST_MARK;
                        end else begin
                            cnt_next = cnt_reg + CW'(1);
                        end
                    end else if (16'(cnt_reg) <= len_full) begin
                        wr_en    = 1'b1;
                        sum_next = sum_plus;
                        cnt_next = cnt_reg + CW'(1);
                    end else if (!skip_reg && (sum_plus != 8'd0)) begin
                        phase_next      = cstb_pkg::PH_ERROR;
                        err_next        = cstb_pkg::ST_PSUM;
                        res_status_next = cstb_pkg::ST_PSUM;
                    end else begin
                        phase_next      = cstb_pkg::PH_READY;
                        orow_next       = 10'd0;
                        ocol_next       = 8'd0;
                        res_status_next = cstb_pkg::ST_OK;
                    end
                end
                cstb_pkg::PH_READY: begin
                    res_status_next = cstb_pkg::ST_OK;
                end
                cstb_pkg::PH_ERROR: begin
                    res_status_next = err_reg;
                end
                default: begin
                    res_status_next = err_reg;
                end
            endcase
        end else begin
            priority case (phase_reg)
                cstb_pkg::PH_READY: begin
                    if (r_a >= rows_eff) begin
                        orow_next       = (r_a > rows_eff) ? rows_eff : r_a;
                        ocol_next       = 8'd0;
                        res_status_next = cstb_pkg::ST_NOTHING;
                    end else begin
                        rd_hit          = 1'b1;
                        res_last_next   = last_hit;
                        orow_next       = r_n;
                        ocol_next       = c_n;
                        res_status_next = cstb_pkg::ST_OK;
                    end
                end
                cstb_pkg::PH_ERROR: begin
                    res_status_next = err_reg;
                end
                default: begin
                    res_status_next = cstb_pkg::ST_NOTHING;
                end
            endcase
        end
        res_w_next = magnify_reg ? {cols_next, 2'b00} : 10'(cols_next);
        res_h_next = magnify_reg ? {rows_next, 2'b00} : 10'(rows_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg    <= 1'b0;
            magnify_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                cstb_pkg::CFG_SKIP_CHECKS: skip_reg    <= cfg_data;
                cstb_pkg::CFG_MAGNIFY:     magnify_reg <= cfg_data;
                default:                   skip_reg    <= skip_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= cstb_pkg::PH_HEADER;
            err_reg   <= cstb_pkg::ST_LOADING;
            cnt_reg   <= '0;
            sum_reg   <= 8'd0;
            rows_reg  <= 8'd0;
            cols_reg  <= 8'd0;
            orow_reg  <= 10'd0;
            ocol_reg  <= 8'd0;
        end else if (cmd.exec) begin
            phase_reg <= phase_next;
            err_reg   <= err_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            rows_reg  <= rows_next;
            cols_reg  <= cols_next;
            orow_reg  <= orow_next;
            ocol_reg  <= ocol_next;
        end
    end

    // accepted word and result staging
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= s_opcode;
            byte_reg <= s_in_byte;
        end
        if (cmd.exec) begin
            addr_reg       <= AW'(addr_full);
            part_reg       <= c_a[1:0];
            mag_used_reg   <= magnify_reg;
            res_status_reg <= res_status_next;
            res_byte_reg   <= 8'd0;
            res_last_reg   <= res_last_next;
            res_w_reg      <= res_w_next;
            res_h_reg      <= res_h_next;
        end
        if (cmd.form) begin
            if (mag_used_reg) begin
                res_byte_reg <= {{4{rd_data_reg[3'd7 - {part_reg, 1'b0}]}},
                                 {4{rd_data_reg[3'd6 - {part_reg, 1'b0}]}}};
            end else begin
                res_byte_reg <= rd_data_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && wr_en) mem[wr_addr] <= byte_reg;
        if (cmd.mem_rd) rd_data_reg <= mem[addr_reg];
    end

    // output register, refilled while the previous word drains
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_status_reg <= res_status_reg;
            m_byte_reg   <= res_byte_reg;
            m_last_reg   <= res_last_reg;
            m_w_reg      <= res_w_reg;
            m_h_reg      <= res_h_reg;
        end
    end

    assign stat.need_mem  = rd_hit;
    assign stat.slot_free = !m_valid_reg || m_ready;

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_out_byte       = m_byte_reg;
    assign m_last_byte      = m_last_reg;
    assign m_picture_width  = m_w_reg;
    assign m_picture_height = m_h_reg;

    `CSTB_ASSERT_IMPLY(a_wr_in_payload, cmd.exec && wr_en, phase_reg == cstb_pkg::PH_PAYLOAD, "payload write outside payload phase")
    `CSTB_ASSERT_IMPLY(a_rd_in_image, cmd.exec && rd_hit, addr_full < 17'(len_full), "readout address beyond stored payload")
    `CSTB_ASSERT_IMPLY(a_cnt_bound, phase_reg == cstb_pkg::PH_PAYLOAD, 17'(cnt_reg) <= 17'(len_full) + 17'd1, "payload position past checksum")
    `CSTB_ASSERT_NEXT(a_err_sticky, phase_reg == cstb_pkg::PH_ERROR, phase_reg == cstb_pkg::PH_ERROR && $stable(err_reg), "error state left before reset")

endmodule

>>> sv/calc_screendump_to_bitmap.sv
// Screendump loader and bitmap readout.
// Input channel s_*: s_opcode 0 loads s_in_byte as the next file byte, 1 asks for the
// next raster byte. Each input word yields exactly one result word on m_*: raster
// byte, last-byte flag, status, and the output picture width and height.
// Configuration: cfg_wr_en writes cfg_data to register cfg_index (0 skip_checks,
// 1 magnify); the user must do so only while the block is idle; it does not check.
// Steps: a load word runs execute then push; a read word that hits the image runs execute,
// memory read, bit expansion and push, and any other read word runs execute then push.
// s_ready returns in the cycle after the push, so a new word is taken only once the
// previous one has been pushed.
// The output register holds one finished word; the next word is accepted and worked
// on while it waits. If the receiver stalls, the block stalls at the push step.
// Reset (aresetn low, synchronous) returns to header parsing with both registers
// cleared and s_ready low; the payload memory is not cleared and needs no clearing pass.
// Errors are sticky until reset.
// depends on cstb_pkg, cstb_ctrl and cstb_datapath
module calc_screendump_to_bitmap (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic        cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last_byte,
    output logic [2:0]  m_status,
    output logic [9:0]  m_picture_width,
    output logic [9:0]  m_picture_height
);

    cstb_pkg::cstb_cmd_t  cmd;
    cstb_pkg::cstb_stat_t stat;

    cstb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cstb_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_opcode         (s_opcode),
        .s_in_byte        (s_in_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_last_byte      (m_last_byte),
        .m_status         (m_status),
        .m_picture_width  (m_picture_width),
        .m_picture_height (m_picture_height),
        .cmd              (cmd),
        .stat             (stat)
    );

endmodule

>>> tb/raster_sb_pkg.sv
`timescale 1ns / 1ps
// scoreboard for the screendump loader testbench: a bit-exact predictor of the
// result word for every accepted input word, plus the in-order result check; depends on cstb_pkg
package raster_sb_pkg;
    import cstb_pkg::*;

    typedef struct packed {
        logic [7:0] pix;
        logic       last;
        status_t    st;
        logic [9:0] width;
        logic [9:0] height;
    } raster_word_t;

    class raster_scoreboard;
        bit           skip_checks;
        bit           magnify;
        phase_t       ph;
        status_t      err;
        int           cnt;
        logic [7:0]   sum;
        logic [7:0]   rows;
        logic [7:0]   cols;
        logic [7:0]   store [PAYLOAD_DEPTH];
        int           rd_row;
        int           rd_col;
        raster_word_t raster_due[$];
        int           mismatches;
        int           words_checked;
        int           raster_bytes;

        function new();
            skip_checks   = 1'b0;
            magnify       = 1'b0;
            ph            = PH_HEADER;
            err           = ST_LOADING;
            cnt           = 0;
            sum           = 8'd0;
            rows          = 8'd0;
            cols          = 8'd0;
            rd_row        = 0;
            rd_col        = 0;
            mismatches    = 0;
            words_checked = 0;
            raster_bytes  = 0;
        endfunction

        function void write_reg(logic idx, logic val);
            if (idx == CFG_SKIP_CHECKS) skip_checks = val;
            else magnify = val;
        endfunction

        function int src_row_bytes();
            return (int'(cols) + 7) / 8;
        endfunction

        function status_t fail(status_t code);
            ph  = PH_ERROR;
            err = code;
            return code;
        endfunction

        function status_t take_byte(logic [7:0] b);
            logic [7:0] total;
            total = sum + b;
            case (ph)
                PH_HEADER: begin
                    if ((cnt == 0 && b != SIG_COLON) || ((cnt == 1 || cnt == 2) && b != SIG_D))
                        return fail(ST_SIG);
                    if (cnt == 3) rows = b;
                    if (cnt == 4) cols = b;
                    if (cnt + 1 < HEADER_BYTES) begin
                        // the leading colon is not part of the header sum
                        if (cnt >= 1) sum = total;
                        cnt++;
                        return ST_LOADING;
                    end
                    if (!skip_checks && total != 8'd0) return fail(ST_HSUM);
                    if (rows == 8'd0 || cols == 8'd0 ||
                        int'(rows) * src_row_bytes() > PAYLOAD_DEPTH)
                        return fail(ST_SIZE);
                    ph  = PH_PAYLOAD;
                    cnt = 0;
                    sum = 8'd0;
                    return ST_LOADING;
                end
                PH_PAYLOAD: begin
                    if (cnt == 0) begin
                        if (b != SIG_COLON) return fail(ST_MARK);
                    end else if (cnt <= int'(rows) * src_row_bytes()) begin
                        store[(cnt - 1) % PAYLOAD_DEPTH] = b;
                        sum = total;
                    end else begin
                        if (!skip_checks && total != 8'd0) return fail(ST_PSUM);
                        ph     = PH_READY;
                        rd_row = 0;
                        rd_col = 0;
                        return ST_OK;
                    end
                    cnt++;
                    return ST_LOADING;
                end
                PH_READY: return ST_OK;
                default:  return err;
            endcase
        endfunction

        // payload is column-major with the rightmost byte column first
        function logic [7:0] src_at(int r, int c);
            return store[((src_row_bytes() - 1 - c) * int'(rows) + r) % PAYLOAD_DEPTH];
        endfunction

        function status_t next_raster_byte(output logic [7:0] pix, output logic last);
            int         n_rows;
            int         rb;
            int         r;
            int         c;
            int         part;
            logic [7:0] s;
            pix  = 8'd0;
            last = 1'b0;
            if (ph == PH_ERROR) return err;
            if (ph != PH_READY) return ST_NOTHING;
            n_rows = magnify ? 4 * int'(rows) : int'(rows);
            rb     = magnify ? (int'(cols) + 1) / 2 : src_row_bytes();
            r      = rd_row;
            c      = rd_col;
            // column left over from a wider geometry wraps to the next row
            if (c >= rb) begin
                c = 0;
                r++;
            end
            if (r >= n_rows) begin
                rd_row = (r > n_rows) ? n_rows : r;
                rd_col = 0;
                return ST_NOTHING;
            end
            if (magnify) begin
                s    = src_at(r / 4, c / 4);
                part = c % 4;
                pix  = {{4{s[7 - 2 * part]}}, {4{s[6 - 2 * part]}}};
            end else begin
                pix = src_at(r, c);
            end
            last = (r == n_rows - 1) && (c == rb - 1);
            c++;
            if (c >= rb) begin
                c = 0;
                r++;
            end
            rd_row = r;
            rd_col = c;
            raster_bytes++;
            return ST_OK;
        endfunction

        function raster_word_t predict_raster_word(logic op, logic [7:0] b);
            raster_word_t res;
            res.pix  = 8'd0;
            res.last = 1'b0;
            if (op == OP_LOAD) res.st = take_byte(b);
            else res.st = next_raster_byte(res.pix, res.last);
            res.width  = magnify ? {cols, 2'b00} : {2'b00, cols};
            res.height = magnify ? {rows, 2'b00} : {2'b00, rows};
            return res;
        endfunction

        function void note_input(logic op, logic [7:0] b);
            raster_due.push_back(predict_raster_word(op, b));
        endfunction

        function void check_result(logic [7:0] pix, logic last, logic [2:0] st,
                                   logic [9:0] width, logic [9:0] height);
            raster_word_t e;
            if (raster_due.size() == 0) begin
                $error("result word with no input word pending");
                mismatches++;
                return;
            end
            e = raster_due.pop_front();
            words_checked++;
            if (pix !== e.pix) begin
                $error("out_byte: expected %0h, got %0h", e.pix, pix);
                mismatches++;
            end
            if (last !== e.last) begin
                $error("last_byte: expected %0d, got %0d", e.last, last);
                mismatches++;
            end
            if (st !== e.st) begin
                $error("status: expected %0d, got %0d", e.st, st);
                mismatches++;
            end
            if (width !== e.width) begin
                $error("picture_width: expected %0d, got %0d", e.width, width);
                mismatches++;
            end
            if (height !== e.height) begin
                $error("picture_height: expected %0d, got %0d", e.height, height);
                mismatches++;
            end
        endfunction
    endclass

endpackage

>>> tb/tb.sv
`timescale 1ns / 1ps
// top of the screendump loader testbench: clock, reset, word and register drivers,
// one random screendump file and random readout traffic; depends on cstb_pkg and raster_sb_pkg
module tb;
    import cstb_pkg::*;
    import raster_sb_pkg::*;

    localparam int WORD_TARGET = 1400;

    typedef enum int {
        FLAW_NONE,
        FLAW_SIG,
        FLAW_HSUM,
        FLAW_SIZE,
        FLAW_MARK,
        FLAW_PSUM
    } flaw_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_index = 1'b0;
    logic       cfg_data  = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic       s_opcode  = 1'b0;
    logic [7:0] s_in_byte = 8'd0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_last_byte;
    logic [2:0] m_status;
    logic [9:0] m_picture_width;
    logic [9:0] m_picture_height;

    raster_scoreboard sb;
    logic [7:0]       file_q[$];
    bit               quiet_run = 1'b0;
    int               words_sent = 0;
    int               reg_writes = 0;

    calc_screendump_to_bitmap dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_in_byte        (s_in_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_last_byte      (m_last_byte),
        .m_status         (m_status),
        .m_picture_width  (m_picture_width),
        .m_picture_height (m_picture_height)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one, none in a quiet stretch
    function automatic int pick_gap();
        int r;
        if (quiet_run) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(input logic op, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_opcode  <= op;
        s_in_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(op, b);
        words_sent++;
    endtask

    // hold off the sender until every pending word has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.raster_due.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic set_reg(input logic idx, input logic val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.write_reg(idx, val);
        reg_writes++;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic void build_file(int rows, int cols, flaw_t flaw, bit loose);
        logic [7:0] sum;
        logic [7:0] b;
        int         n;
        int         i;
        file_q.delete();
        file_q.push_back(SIG_COLON);
        file_q.push_back(SIG_D);
        file_q.push_back(SIG_D);
        file_q.push_back(8'(rows));
        file_q.push_back(8'(cols));
        for (i = 5; i < HEADER_BYTES - 1; i++) file_q.push_back(8'($urandom));
        sum = 8'd0;
        for (i = 1; i < HEADER_BYTES - 1; i++) sum = sum + file_q[i];
        file_q.push_back(loose ? 8'($urandom) : 8'(0 - sum));
        if (flaw == FLAW_HSUM) file_q[HEADER_BYTES - 1] += 8'($urandom_range(1, 255));
        if (flaw == FLAW_SIG) begin
            i = $urandom_range(0, 2);
            file_q[i] ^= 8'($urandom_range(1, 255));
        end
        n = rows * ((cols + 7) / 8);
        file_q.push_back(flaw == FLAW_MARK ? SIG_COLON ^ 8'($urandom_range(1, 255)) : SIG_COLON);
        sum = 8'd0;
        for (i = 0; i < n; i++) begin
            b = 8'($urandom);
            file_q.push_back(b);
            sum = sum + b;
        end
        file_q.push_back(loose ? 8'($urandom) : 8'(0 - sum));
        if (flaw == FLAW_PSUM) file_q[file_q.size() - 1] += 8'($urandom_range(1, 255));
    endfunction

    // receiver side: ready runs broken by random stalls
    initial begin : result_pacing
        int stall;
        forever begin
            @(posedge aclk);
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_out_byte, m_last_byte, m_status, m_picture_width,
                            m_picture_height);
    end

    initial begin : stimulus
        int    rows;
        int    cols;
        int    shape;
        flaw_t flaw;
        bit    skip;
        bit    loose;
        sb = new();

        // pick the one file of the run: mostly clean, now and then broken
        shape = $urandom_range(0, 9);
        if (shape < 2) begin
            rows = $urandom_range(1, 2);
            cols = 255;
        end else if (shape < 4) begin
            rows = 255;
            cols = $urandom_range(1, 8);
        end else begin
            rows = $urandom_range(1, 24);
            cols = $urandom_range(1, 64);
        end
        flaw = FLAW_NONE;
        if ($urandom_range(0, 9) == 0) flaw = flaw_t'($urandom_range(1, 5));
        if (flaw == FLAW_SIZE) begin
            if ($urandom_range(0, 1)) rows = 0;
            else cols = 0;
        end
        skip  = $urandom_range(0, 1);
        if (flaw == FLAW_HSUM || flaw == FLAW_PSUM) skip = 1'b0;
        loose = skip && $urandom_range(0, 1);
        build_file(rows, cols, flaw, loose);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_reg(CFG_MAGNIFY, 1'b1);
        set_reg(CFG_SKIP_CHECKS, 1'b1);
        set_reg(CFG_MAGNIFY, 1'b0);
        set_reg(CFG_SKIP_CHECKS, skip);

        // reads before any file word have nothing to return
        send_word(OP_READ, 8'h00);
        send_word(OP_READ, 8'hFF);
        send_word(OP_READ, 8'h5A);

        foreach (file_q[i]) begin
            if ($urandom_range(0, 19) == 0) send_word(OP_READ, 8'($urandom));
            send_word(OP_LOAD, file_q[i]);
            if ($urandom_range(0, 39) == 0) begin
                drain();
                quiet_run = ($urandom_range(0, 3) == 0);
                set_reg(CFG_MAGNIFY, 1'($urandom_range(0, 1)));
            end
        end
        drain();

        // readout with stray file words; magnify flips mid-image at idle points
        while (words_sent < WORD_TARGET) begin
            if ($urandom_range(0, 99) < 85) send_word(OP_READ, 8'($urandom));
            else send_word(OP_LOAD, 8'($urandom));
            if ($urandom_range(0, 59) == 0) begin
                drain();
                quiet_run = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 1)) set_reg(CFG_MAGNIFY, 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 3) == 0)
                    set_reg(CFG_SKIP_CHECKS, 1'($urandom_range(0, 1)));
            end
        end

        s_valid <= 1'b0;
        while (sb.raster_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("screendump %0d rows x %0d cols, %s, skip_checks %0d, %0d register writes",
                 rows, cols, flaw.name(), skip, reg_writes);
        $display("%0d words sent, %0d result words checked, %0d raster bytes read back",
                 words_sent, sb.words_checked, sb.raster_bytes);
        if (sb.mismatches == 0 && sb.raster_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
